FILE: rtl/rbts_pkg.sv
`default_nettype none
package rbts_pkg;

    localparam int WORD_W   = 32;
    localparam int KIND_W   = 3;
    localparam int CELLS    = 3;
    localparam int SPAN_W   = 80;   // ten bytes checked from the oldest word
    localparam int TAG_N    = 6;

    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EEPROM   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SRAM     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FLASH64  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FLASH128 = 3'd4;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Tag text, byte 0 in bits 7:0, with a mask over the bytes that count.
    typedef struct packed {
        logic [SPAN_W-1:0] text;
        logic [SPAN_W-1:0] mask;
        logic [KIND_W-1:0] kind;
    } tag_t;

    localparam tag_t TAGS [TAG_N] = '{
        // eeprom tag
        '{80'h0000_565F_4D4F_5250_4545, 80'h0000_FFFF_FFFF_FFFF_FFFF, KIND_EEPROM},
        // sram tag
        '{80'h0000_0000_565F_4D41_5253, 80'h0000_0000_FFFF_FFFF_FFFF, KIND_SRAM},
        // sram tag, F variant
        '{80'h0000_565F_465F_4D41_5253, 80'h0000_FFFF_FFFF_FFFF_FFFF, KIND_SRAM},
        // flash tag
        '{80'h0000_0056_5F48_5341_4C46, 80'h0000_00FF_FFFF_FFFF_FFFF, KIND_FLASH64},
        // flash tag, 512 variant
        '{80'h565F_3231_3548_5341_4C46, 80'hFFFF_FFFF_FFFF_FFFF_FFFF, KIND_FLASH64},
        // flash tag, 1M variant
        '{80'h0056_5F4D_3148_5341_4C46, 80'h00FF_FFFF_FFFF_FFFF_FFFF, KIND_FLASH128}
    };

endpackage
`default_nettype wire

FILE: rtl/rbts_cell.sv
`default_nettype none
module rbts_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rbts_pkg::cell_ctrl_t          ctrl,
    input  wire logic [rbts_pkg::WORD_W-1:0]   word_in,
    input  wire logic                          valid_in,
    output logic      [rbts_pkg::WORD_W-1:0]   word_out,
    output logic                               valid_out
);

    logic [rbts_pkg::WORD_W-1:0] word_reg;
    logic                        valid_reg;
    logic                        valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            valid_next = valid_in;
        end
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            word_reg <= word_in;
        end
    end

    assign word_out  = word_reg;
    assign valid_out = valid_reg;

endmodule
`default_nettype wire

FILE: rtl/rbts_matcher.sv
`default_nettype none
module rbts_matcher (
    input  wire logic [rbts_pkg::WORD_W-1:0] word0,
    input  wire logic [rbts_pkg::WORD_W-1:0] word1,
    input  wire logic [rbts_pkg::WORD_W-1:0] word2,
    output logic      [rbts_pkg::KIND_W-1:0] kind
);

    logic [rbts_pkg::SPAN_W-1:0] span;
    logic [rbts_pkg::TAG_N-1:0]  hit;

    assign span = {word2[15:0], word1, word0};

    always_comb
    begin
        for (int t = 0; t < rbts_pkg::TAG_N; t++)
        begin
            hit[t] = ((span ^ rbts_pkg::TAGS[t].text) & rbts_pkg::TAGS[t].mask) == '0;
        end
    end

    // first tag in table order wins
    always_comb
    begin
        kind = rbts_pkg::KIND_NONE;
        for (int t = rbts_pkg::TAG_N - 1; t >= 0; t--)
        begin
            if (hit[t])
            begin
                kind = rbts_pkg::TAGS[t].kind;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/rom_backup_tag_scanner_top.sv
// rom_backup_tag_scanner_top
// Scans a ROM image for backup-media tags at word-aligned offsets.
// Input channel (in_valid/in_ready): one request per ROM word, little-endian,
// with is_final set on the last word of the image.
// Output channel (out_valid/out_ready): one request per image, carrying
// save_kind (0 none, 1 eeprom, 2 sram, 3 flash 64KiB, 4 flash 128KiB).
// Throughput: one word per cycle while the output is not stalled, through a row
// of three word cells that shift in step with each accepted word.
// save_kind is registered, valid in the cycle after the final word is taken.
// A position is checked when the third word after it arrives, so the last
// three words of an image never start a tag; images under four words give 0.
// The first matching position sets the kind; later matches are ignored.
// Stall: the result sits in an output register; while it waits and
// out_ready is low, in_ready drops. Non-final words still flow while the
// output register is empty.
// Reset: asynchronous, clears the cell valid bits, the match flag and the
// output valid; the block is ready on the first cycle after reset.
`default_nettype none
module rom_backup_tag_scanner_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rbts_pkg::WORD_W-1:0]   rom_word,
    input  wire logic                          is_final,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [rbts_pkg::KIND_W-1:0]   save_kind
);

    localparam int CELLS = rbts_pkg::CELLS;

    logic [rbts_pkg::WORD_W-1:0] cell_word  [CELLS];
    logic                        cell_valid [CELLS];
    rbts_pkg::cell_ctrl_t        cell_ctrl;

    logic                        accept;
    logic                        window_full;
    logic [rbts_pkg::KIND_W-1:0] match_kind;
    logic [rbts_pkg::KIND_W-1:0] check_kind;
    logic [rbts_pkg::KIND_W-1:0] image_kind;

    logic                        found_reg,     found_next;
    logic [rbts_pkg::KIND_W-1:0] kind_reg,      kind_next;
    logic                        out_valid_reg, out_valid_next;
    logic [rbts_pkg::KIND_W-1:0] out_kind_reg,  out_kind_next;

    // Output register frees itself when taken, so a new word can enter
    // in the same cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = accept && is_final;

    // Cell 0 holds the oldest word, cell CELLS-1 the newest.
    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        if (i == CELLS - 1)
        begin : g_head
            rbts_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .word_in   (rom_word),
                .valid_in  (1'b1),
                .word_out  (cell_word[i]),
                .valid_out (cell_valid[i])
            );
        end
        else
        begin : g_body
            rbts_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .word_in   (cell_word[i+1]),
                .valid_in  (cell_valid[i+1]),
                .word_out  (cell_word[i]),
                .valid_out (cell_valid[i])
            );
        end
    end

    // Valid bits fill from the head, so the oldest cell being valid means
    // the whole window is full.
    assign window_full = cell_valid[0];

    rbts_matcher u_matcher (
        .word0 (cell_word[0]),
        .word1 (cell_word[1]),
        .word2 (cell_word[2]),
        .kind  (match_kind)
    );

    // Window is checked against the words held before this request shifts in.
    assign check_kind = (window_full && !found_reg) ? match_kind : rbts_pkg::KIND_NONE;
    assign image_kind = found_reg ? kind_reg : check_kind;

    always_comb
    begin
        found_next     = found_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        if (accept)
        begin
            if (is_final)
            begin
                found_next     = 1'b0;
                kind_next      = rbts_pkg::KIND_NONE;
                out_valid_next = 1'b1;
                out_kind_next  = image_kind;
            end
            else
            begin
                found_next = found_reg || (check_kind != rbts_pkg::KIND_NONE);
                kind_next  = image_kind;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            kind_reg      <= rbts_pkg::KIND_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg     <= found_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
    end

    assign out_valid = out_valid_reg;
    assign save_kind = out_kind_reg;

endmodule
`default_nettype wire

FILE: rtl/rbts_checker.sv
`default_nettype none
module rbts_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          is_final,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [rbts_pkg::KIND_W-1:0]   save_kind
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(save_kind))
        else $error("result dropped or changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> save_kind <= rbts_pkg::KIND_FLASH128)
        else $error("save_kind out of range");

    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result is blocked");

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && is_final |=> out_valid)
        else $error("final word gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !is_final && !out_valid |=> !out_valid)
        else $error("result without final word");

endmodule

bind rom_backup_tag_scanner_top rbts_checker u_rbts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .is_final  (is_final),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .save_kind (save_kind)
);
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Tag slots in the scanner's own table; also used to place tags in images.
    localparam int NO_TAG       = -1;
    localparam int TAG_EEPROM   = 0;
    localparam int TAG_SRAM     = 1;
    localparam int TAG_SRAM_F   = 2;
    localparam int TAG_FLASH    = 3;
    localparam int TAG_FLASH512 = 4;
    localparam int TAG_FLASH1M  = 5;

    // How the words of an image are filled before tags go in.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam int RANDOM_WORDS = 900;
    localparam int LONG_HOLD    = 300;

    // One input request as queued for the driver. 'drain' makes the sender
    // wait, before offering it, until every outstanding result has come back.
    typedef struct packed {
        logic [rbts_pkg::WORD_W-1:0] word;
        logic                        last;
        logic                        drain;
    } rom_req_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic [rbts_pkg::WORD_W-1:0]   rom_word  = '0;
    logic                          is_final  = 1'b0;
    logic                          out_ready = 1'b0;
    wire                           in_ready;
    wire                           out_valid;
    wire  [rbts_pkg::KIND_W-1:0]   save_kind;

    rom_backup_tag_scanner_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rom_word  (rom_word),
        .is_final  (is_final),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .save_kind (save_kind)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Tag table: text with byte 0 in bits 7:0, and a mask over its bytes.
    // ------------------------------------------------------------------
    logic [rbts_pkg::SPAN_W-1:0] tag_text [rbts_pkg::TAG_N];
    logic [rbts_pkg::SPAN_W-1:0] tag_mask [rbts_pkg::TAG_N];
    logic [rbts_pkg::KIND_W-1:0] tag_kind [rbts_pkg::TAG_N];
    int                          tag_len  [rbts_pkg::TAG_N];

    // Every tag ends in an underscore and V; callers give the stem only.
    task automatic add_tag(input int slot, input string stem,
                           input logic [rbts_pkg::KIND_W-1:0] k);
        string s;
        int i;
        s = {stem, "_V"};
        tag_text[slot] = '0;
        tag_mask[slot] = '0;
        for (i = 0; i < s.len(); i++)
        begin
            tag_text[slot][8*i +: 8] = s[i];
            tag_mask[slot][8*i +: 8] = 8'hFF;
        end
        tag_kind[slot] = k;
        tag_len[slot]  = s.len();
    endtask

    // ------------------------------------------------------------------
    // Scanner prediction: three-word window, oldest in slot 0. The position
    // of the oldest word is checked (ten bytes) before each new word shifts
    // in, once the window is full and nothing has matched yet.
    // ------------------------------------------------------------------
    logic [rbts_pkg::WORD_W-1:0] win [3];
    int                          win_fill;
    logic                        tag_seen;
    logic [rbts_pkg::KIND_W-1:0] first_kind;
    logic [rbts_pkg::KIND_W-1:0] expected_kinds [$];

    function automatic logic [rbts_pkg::KIND_W-1:0] tag_at_oldest();
        logic [rbts_pkg::SPAN_W-1:0] span;
        int t;
        span = {win[2][15:0], win[1], win[0]};
        for (t = 0; t < rbts_pkg::TAG_N; t++)
            if ((span & tag_mask[t]) == tag_text[t])
                return tag_kind[t];
        return rbts_pkg::KIND_NONE;
    endfunction

    task automatic clear_scan();
        win[0]     = '0;
        win[1]     = '0;
        win[2]     = '0;
        win_fill   = 0;
        tag_seen   = 1'b0;
        first_kind = rbts_pkg::KIND_NONE;
    endtask

    task automatic scan_rom_word(input logic [rbts_pkg::WORD_W-1:0] w, input logic last);
        logic [rbts_pkg::KIND_W-1:0] k;
        if (win_fill >= 3 && !tag_seen)
        begin
            k = tag_at_oldest();
            if (k != rbts_pkg::KIND_NONE)
            begin
                tag_seen   = 1'b1;
                first_kind = k;
            end
        end
        win[0] = win[1];
        win[1] = win[2];
        win[2] = w;
        if (win_fill < 3)
            win_fill++;
        if (last)
        begin
            expected_kinds.push_back(first_kind);
            clear_scan();
        end
    endtask

    // ------------------------------------------------------------------
    // Image building: fill, drop up to two tags at word offsets (bytes past
    // the end of the image are cut off), optionally spoil one tag byte.
    // ------------------------------------------------------------------
    rom_req_t                    pend_q [$];
    logic [rbts_pkg::WORD_W-1:0] img_words [$];
    int                          words_queued = 0;
    int                          images_queued = 0;

    task automatic put_tag(input int t, input int pos, input bit spoil);
        int i;
        int bad;
        int wi;
        logic [rbts_pkg::WORD_W-1:0] w;
        logic [7:0] b;
        bad = spoil ? $urandom_range(0, tag_len[t] - 1) : -1;
        for (i = 0; i < tag_len[t]; i++)
        begin
            wi = pos + i / 4;
            if (wi < img_words.size())
            begin
                b = tag_text[t][8*i +: 8];
                if (i == bad)
                    b = b ^ 8'($urandom_range(1, 255));
                w = img_words[wi];
                w[8*(i%4) +: 8] = b;
                img_words[wi] = w;
            end
        end
    endtask

    task automatic queue_image(input int len, input int t_a, input int p_a,
                               input int t_b, input int p_b, input int fill,
                               input bit spoil, input bit drain);
        int i;
        rom_req_t r;
        img_words.delete();
        for (i = 0; i < len; i++)
            case (fill)
                FILL_ZERO: img_words.push_back('0);
                FILL_ONES: img_words.push_back('1);
                default:   img_words.push_back($urandom);
            endcase
        if (t_a != NO_TAG)
            put_tag(t_a, p_a, spoil);
        if (t_b != NO_TAG)
            put_tag(t_b, p_b, 1'b0);
        for (i = 0; i < len; i++)
        begin
            r.word  = img_words[i];
            r.last  = (i == len - 1);
            r.drain = drain && (i == 0);
            pend_q.push_back(r);
        end
        words_queued += len;
        images_queued++;
    endtask

    task automatic queue_random_image(input bit drain);
        int len;
        int r;
        int t_a;
        int t_b;
        int p_a;
        int p_b;
        int fill;
        r = $urandom_range(0, 99);
        if (r < 8)
            len = $urandom_range(1, 3);
        else if (r < 92)
            len = $urandom_range(4, 12);
        else
            len = $urandom_range(13, 40);
        // Mostly tags at positions that can still be checked; some land in
        // the last three words, where they must be ignored.
        t_a = ($urandom_range(0, 99) < 25) ? NO_TAG : $urandom_range(0, rbts_pkg::TAG_N - 1);
        if (len > 3 && $urandom_range(0, 99) < 80)
            p_a = $urandom_range(0, len - 4);
        else
            p_a = $urandom_range(0, len - 1);
        t_b = ($urandom_range(0, 99) < 25) ? $urandom_range(0, rbts_pkg::TAG_N - 1) : NO_TAG;
        p_b = $urandom_range(0, len - 1);
        r = $urandom_range(0, 99);
        fill = (r < 85) ? FILL_RANDOM : (r < 93) ? FILL_ZERO : FILL_ONES;
        queue_image(len, t_a, p_a, t_b, p_b, fill, $urandom_range(0, 99) < 15, drain);
    endtask

    // ------------------------------------------------------------------
    // Idling. While cycle_cnt[9:8] is 3, one stretch in four, no new gaps are picked.
    // ------------------------------------------------------------------
    logic [31:0] cycle_cnt = '0;
    wire         calm = (cycle_cnt[9:8] == 2'b11);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers one request at a time from pend_q, holds it until taken.
    // ------------------------------------------------------------------
    logic     in_taken = 1'b0;
    int       send_gap = 0;
    rom_req_t next_req;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pend_q.size() != 0 && (!pend_q[0].drain || expected_kinds.size() == 0))
            begin
                next_req = pend_q.pop_front();
                rom_word <= next_req.word;
                is_final <= next_req.last;
                in_valid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off once 20 results
    // are in, so the result register fills and the input backs up.
    // ------------------------------------------------------------------
    int kinds_checked  = 0;
    int recv_hold      = 0;
    bit long_hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            out_ready <= 1'b0;
        end
        else if (!long_hold_done && kinds_checked >= 20)
        begin
            long_hold_done <= 1'b1;
            recv_hold      <= LONG_HOLD - 1;
            out_ready      <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            recv_hold <= pick_gap();
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: results are checked before the word taken on the same edge
    // is predicted, so a fresh expectation is never matched early.
    // ------------------------------------------------------------------
    int                          fail_cnt    = 0;
    int                          words_taken = 0;
    int                          kind_hits [5] = '{0, 0, 0, 0, 0};
    logic [rbts_pkg::KIND_W-1:0] want_kind;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        in_taken  <= in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_kinds.size() == 0)
                begin
                    $error("save_kind: result with none expected, actual %0d", save_kind);
                    fail_cnt++;
                end
                else
                begin
                    want_kind = expected_kinds.pop_front();
                    if (save_kind !== want_kind)
                    begin
                        $error("save_kind mismatch: expected %0d, actual %0d",
                               want_kind, save_kind);
                        fail_cnt++;
                    end
                    if (want_kind <= rbts_pkg::KIND_FLASH128)
                        kind_hits[want_kind]++;
                    kinds_checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                scan_rom_word(rom_word, is_final);
                words_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and the end of the run.
    // ------------------------------------------------------------------
    initial
    begin
        add_tag(TAG_EEPROM,   "EEPROM",   rbts_pkg::KIND_EEPROM);
        add_tag(TAG_SRAM,     "SRAM",     rbts_pkg::KIND_SRAM);
        add_tag(TAG_SRAM_F,   "SRAM_F",   rbts_pkg::KIND_SRAM);
        add_tag(TAG_FLASH,    "FLASH",    rbts_pkg::KIND_FLASH64);
        add_tag(TAG_FLASH512, "FLASH512", rbts_pkg::KIND_FLASH64);
        add_tag(TAG_FLASH1M,  "FLASH1M",  rbts_pkg::KIND_FLASH128);
        clear_scan();

        // Directed: lone all-ones word; tag in a three-word image (too short);
        // tags right at the first checkable position; a first tag with a second
        // one in the last three words; a tag alone inside the last three words.
        queue_image(1, NO_TAG, 0, NO_TAG, 0, FILL_ONES, 1'b0, 1'b0);
        queue_image(3, TAG_EEPROM, 0, NO_TAG, 0, FILL_ZERO, 1'b0, 1'b0);
        queue_image(4, TAG_EEPROM, 0, NO_TAG, 0, FILL_ZERO, 1'b0, 1'b0);
        queue_image(4, TAG_FLASH512, 0, NO_TAG, 0, FILL_ONES, 1'b0, 1'b0);
        queue_image(5, TAG_FLASH1M, 0, TAG_SRAM_F, 3, FILL_RANDOM, 1'b0, 1'b0);
        queue_image(4, TAG_SRAM, 1, NO_TAG, 0, FILL_ZERO, 1'b0, 1'b0);
        queue_image(4, TAG_SRAM_F, 0, NO_TAG, 0, FILL_RANDOM, 1'b0, 1'b1);

        // Random images; the first one always waits for a full drain.
        queue_random_image(1'b1);
        while (words_queued < RANDOM_WORDS)
            queue_random_image($urandom_range(0, 99) < 8);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_kinds.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d images, %0d ROM words; results checked: %0d", images_queued,
                 words_taken, kinds_checked);
        $display("  by kind none/eeprom/sram/flash64k/flash128k: %0d/%0d/%0d/%0d/%0d",
                 kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4]);
        if (fail_cnt == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Watchdog: ends the run as NOT OK far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rbts_pkg.sv
rtl/rbts_cell.sv
rtl/rbts_matcher.sv
rtl/rom_backup_tag_scanner_top.sv
rtl/rbts_checker.sv
sim/tb_top.sv
